### design/framebuffer_pixel_writer_unit_defines.svh
// Assertion macros shared by the checker of the pixel writer.
// Both sample on the rising edge of aclk and stay quiet while aresetn is low.
`ifndef FRAMEBUFFER_PIXEL_WRITER_UNIT_DEFINES_SVH
`define FRAMEBUFFER_PIXEL_WRITER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fpw_pkg.sv
`timescale 1ns / 1ps

package fpw_pkg;

    // Width of a channel mask and of the pixel word.
    localparam int MASK_BITS   = 32;
    localparam int SHIFT_BITS  = $clog2(MASK_BITS);
    localparam int WIDTH_BITS  = $clog2(MASK_BITS + 1);
    localparam int OFFSET_BITS = 34;
    localparam int QUOT_BITS   = 25;
    localparam int REM_BITS    = 7;
    localparam int CFG_INDEX_BITS = 3;

    // Largest number of bytes a pixel word can supply.
    localparam logic [2:0] MAX_BYTES = 3'd4;
    localparam logic [2:0] RESET_BYTES_PER_PIXEL = 3'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GRAPHICS_ENABLED = 3'd0,
        CFG_BYTES_PER_PIXEL  = 3'd1,
        CFG_LINE_PITCH       = 3'd2,
        CFG_LIMIT_X          = 3'd3,
        CFG_LIMIT_Y          = 3'd4,
        CFG_RED_MASK         = 3'd5,
        CFG_GREEN_MASK       = 3'd6,
        CFG_BLUE_MASK        = 3'd7
    } cfg_index_e;

    typedef struct packed {
        logic [23:0] rgb_color;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } pixel_in_t;

    typedef struct packed {
        logic                   write_valid;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [MASK_BITS-1:0]   pixel_word;
        logic [2:0]             byte_count;
    } pixel_out_t;

    // A channel mask reduced to its position and the scale factor of its width:
    // 2^width - 1 = 255 * quot + rem.
    typedef struct packed {
        logic [SHIFT_BITS-1:0] shift;
        logic [QUOT_BITS-1:0]  quot;
        logic [REM_BITS-1:0]   rem;
    } chan_param_t;

    typedef struct packed {
        logic        graphics_enabled;
        logic [2:0]  bytes_per_pixel;
        logic [17:0] line_pitch;
        logic [15:0] limit_x;
        logic [15:0] limit_y;
        chan_param_t red;
        chan_param_t green;
        chan_param_t blue;
    } cfg_t;

    // Finds the lowest run of ones in a mask. Adding the lowest set bit to the
    // mask clears the run and sets the bit just above it, so both run ends are
    // one-hot vectors that encode to indexes with plain OR trees. Since
    // 2^8 = 1 mod 255, the quotient of 2^width - 1 by 255 is a repeated 0x01
    // byte pattern shifted by width mod 8, and the remainder is 2^(width mod 8) - 1.
    function automatic chan_param_t decode_mask(input logic [MASK_BITS-1:0] mask);
        logic [MASK_BITS-1:0]  low_bit;
        logic [MASK_BITS:0]    run_sum;
        logic [MASK_BITS:0]    top_bit;
        logic [SHIFT_BITS-1:0] low_idx;
        logic [WIDTH_BITS-1:0] top_idx;
        logic [WIDTH_BITS-1:0] width;
        logic [2:0]            bytes_full;
        logic [2:0]            bits_left;
        logic [QUOT_BITS-1:0]  repeat_ones;
        chan_param_t           param;
        low_bit = mask & (~mask + 1'b1);
        run_sum = {1'b0, mask} + {1'b0, low_bit};
        top_bit = run_sum & ~{1'b0, mask};
        low_idx = '0;
        top_idx = '0;
        for (int i = 0; i < MASK_BITS; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | SHIFT_BITS'(i);
            end
        end
        for (int i = 0; i <= MASK_BITS; i++) begin
            if (top_bit[i]) begin
                top_idx = top_idx | WIDTH_BITS'(i);
            end
        end
        width      = top_idx - WIDTH_BITS'(low_idx);
        bytes_full = width[5:3];
        bits_left  = width[2:0];
        unique case (bytes_full)
            3'd0:    repeat_ones = QUOT_BITS'(32'h0000_0000);
            3'd1:    repeat_ones = QUOT_BITS'(32'h0000_0001);
            3'd2:    repeat_ones = QUOT_BITS'(32'h0000_0101);
            3'd3:    repeat_ones = QUOT_BITS'(32'h0001_0101);
            default: repeat_ones = QUOT_BITS'(32'h0101_0101);
        endcase
        param.shift = low_idx;
        param.quot  = repeat_ones << bits_left;
        param.rem   = REM_BITS'((8'd1 << bits_left) - 8'd1);
        return param;
    endfunction

endpackage

### design/framebuffer_pixel_writer_unit.sv
`timescale 1ns / 1ps

// Framebuffer pixel writer: takes one RGB888 color and an x,y position per
// transfer and returns the framebuffer byte offset, the pixel word packed
// through the red, green and blue masks, the byte count and a write flag.
// A pixel passes through an input register, one pass of combinational logic
// (one 18x16 offset product and three 25x8 channel products) and a result
// register. A result is presented on m_valid from the result register, which
// holds it while m_ready is low. One pixel per clock is sustained for as long
// as m_ready stays high. Configuration writes are never stalled (cfg_ready
// is always high); a mask is decoded into shift and scale when it is written,
// and registers may only change while no pixel is in flight.
module framebuffer_pixel_writer_unit
    import fpw_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  pixel_in_t                 s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output pixel_out_t                m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [MASK_BITS-1:0]      cfg_data
);

    cfg_t                   cfg;
    logic                   in_valid_reg;
    pixel_in_t              in_data_reg;
    logic                   out_valid_reg;
    pixel_out_t             out_data_reg;
    pixel_out_t             result_next;
    logic                   out_ready;
    logic                   advance;
    logic [MASK_BITS-1:0]   red_contrib;
    logic [MASK_BITS-1:0]   green_contrib;
    logic [MASK_BITS-1:0]   blue_contrib;
    logic [OFFSET_BITS-1:0] pitch_term;
    logic [18:0]            bpp_term;
    logic [2:0]             count;

    fpw_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the result register frees when empty or taken, and the input
    // register moves on whenever the result register frees.
    assign out_ready = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    // Per-channel scaling of the color.
    fpw_channel_scale u_red (
        .intensity (in_data_reg.rgb_color[23:16]),
        .param     (cfg.red),
        .contrib   (red_contrib)
    );

    fpw_channel_scale u_green (
        .intensity (in_data_reg.rgb_color[15:8]),
        .param     (cfg.green),
        .contrib   (green_contrib)
    );

    fpw_channel_scale u_blue (
        .intensity (in_data_reg.rgb_color[7:0]),
        .param     (cfg.blue),
        .contrib   (blue_contrib)
    );

    // Offset, byte count and write decision.
    always_comb begin
        pitch_term = OFFSET_BITS'(cfg.line_pitch * in_data_reg.pos_y);
        bpp_term   = cfg.bytes_per_pixel * in_data_reg.pos_x;
        count      = (cfg.bytes_per_pixel > MAX_BYTES) ? MAX_BYTES : cfg.bytes_per_pixel;

        result_next.write_valid = cfg.graphics_enabled
                               && (in_data_reg.pos_x < cfg.limit_x)
                               && (in_data_reg.pos_y < cfg.limit_y)
                               && (count != 3'd0);
        result_next.byte_offset = pitch_term + OFFSET_BITS'(bpp_term);
        result_next.pixel_word  = red_contrib | green_contrib | blue_contrib;
        result_next.byte_count  = count;
    end

    // Valid flags of both registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

### design/fpw_cfg_regs.sv
`timescale 1ns / 1ps

module fpw_cfg_regs
    import fpw_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [MASK_BITS-1:0]      cfg_data,
    output cfg_t                      cfg
);

    cfg_t        cfg_reg;
    chan_param_t mask_param;

    // Writes are always accepted.
    assign cfg_ready = 1'b1;

    // Masks are reduced to shift and scale at write time.
    assign mask_param = decode_mask(cfg_data);

    // Register file update on each configuration transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.graphics_enabled <= 1'b0;
            cfg_reg.bytes_per_pixel  <= RESET_BYTES_PER_PIXEL;
            cfg_reg.line_pitch       <= '0;
            cfg_reg.limit_x          <= '0;
            cfg_reg.limit_y          <= '0;
            cfg_reg.red              <= '0;
            cfg_reg.green            <= '0;
            cfg_reg.blue             <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_e'(cfg_index))
                CFG_GRAPHICS_ENABLED: cfg_reg.graphics_enabled <= cfg_data[0];
                CFG_BYTES_PER_PIXEL:  cfg_reg.bytes_per_pixel  <= cfg_data[2:0];
                CFG_LINE_PITCH:       cfg_reg.line_pitch       <= cfg_data[17:0];
                CFG_LIMIT_X:          cfg_reg.limit_x          <= cfg_data[15:0];
                CFG_LIMIT_Y:          cfg_reg.limit_y          <= cfg_data[15:0];
                CFG_RED_MASK:         cfg_reg.red              <= mask_param;
                CFG_GREEN_MASK:       cfg_reg.green            <= mask_param;
                CFG_BLUE_MASK:        cfg_reg.blue             <= mask_param;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/fpw_channel_scale.sv
`timescale 1ns / 1ps

module fpw_channel_scale
    import fpw_pkg::*;
(
    input  logic [7:0]           intensity,
    input  chan_param_t          param,
    output logic [MASK_BITS-1:0] contrib
);

    logic [QUOT_BITS+7:0]  quot_term;
    logic [REM_BITS+7:0]   rem_prod;
    logic [15:0]           rem_inc;
    logic [15:0]           rem_sum;
    logic [7:0]            rem_term;
    logic [MASK_BITS-1:0]  scaled;

    // The whole part of the scale is a plain product.
    assign quot_term = param.quot * intensity;

    // The remainder part needs floor(x / 255) for x below 2^15, done as
    // (x + 1 + ((x + 1) >> 8)) >> 8.
    assign rem_prod = param.rem * intensity;
    assign rem_inc  = 16'(rem_prod) + 16'd1;
    assign rem_sum  = rem_inc + (rem_inc >> 8);
    assign rem_term = rem_sum[15:8];

    // Combine both parts and move the value into its field.
    assign scaled  = quot_term[MASK_BITS-1:0] + MASK_BITS'(rem_term);
    assign contrib = scaled << param.shift;

endmodule

### design/fpw_checker.sv
`timescale 1ns / 1ps
`include "framebuffer_pixel_writer_unit_defines.svh"

module fpw_checker
    import fpw_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input pixel_out_t m_data
);

    // A stalled result stays put until its transfer.
    `FPW_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

    // An empty result register never blocks the input side.
    `FPW_ASSERT_SAME(a_ready_when_empty, !m_valid, s_ready, "input blocked with no result pending")

    // The byte count never exceeds the width of the pixel word.
    `FPW_ASSERT_SAME(a_count_range, m_valid, m_data.byte_count <= MAX_BYTES, "byte count above four")

    // A write that happens always writes at least one byte.
    `FPW_ASSERT_SAME(a_write_has_bytes, m_valid && m_data.write_valid, m_data.byte_count != 3'd0, "write with zero bytes")

endmodule

bind framebuffer_pixel_writer_unit fpw_checker u_fpw_checker (.*);

### verif/tb_framebuffer_pixel_writer_unit.sv
`timescale 1ns / 1ps

module tb_framebuffer_pixel_writer_unit;
    import fpw_pkg::*;

    // Clock, reset and the signals around the block under test.
    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    pixel_in_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    pixel_out_t m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [MASK_BITS-1:0]      cfg_data = '0;

    // Our own copy of the configuration registers, updated on each accepted write.
    logic        fb_enabled;
    logic [2:0]  fb_bpp;
    logic [17:0] fb_pitch;
    logic [15:0] fb_limit_x;
    logic [15:0] fb_limit_y;
    logic [31:0] fb_red_mask;
    logic [31:0] fb_green_mask;
    logic [31:0] fb_blue_mask;

    // Pixels waiting to be offered, and the predicted writes still owed by the block.
    pixel_in_t  pixel_pending_q[$];
    pixel_out_t pixel_expect_q[$];

    int   error_count = 0;
    int   items_sent = 0;
    int   results_checked = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   hold_left = 0;
    logic hold_req = 1'b0;
    logic idle_on = 1'b1;

    framebuffer_pixel_writer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Scales one 8-bit intensity to the lowest run of ones in the mask and moves it
    // into place. An empty mask contributes nothing.
    function automatic logic [31:0] scale_channel(input logic [31:0] mask,
                                                  input logic [7:0] level);
        int          lsb;
        int          run;
        logic [63:0] full_scale;
        logic [63:0] scaled;
        if (mask == '0) begin
            return '0;
        end
        lsb = 0;
        while (lsb < 32 && !mask[lsb]) begin
            lsb++;
        end
        run = 0;
        while (lsb + run < 32 && mask[lsb + run]) begin
            run++;
        end
        full_scale = (64'd1 << run) - 64'd1;
        scaled = (full_scale * 64'(level)) / 64'd255;
        return 32'(scaled << lsb);
    endfunction

    // Expected framebuffer write for one pixel under the current register values.
    function automatic pixel_out_t predict_pixel(input pixel_in_t px);
        pixel_out_t  res;
        logic [2:0]  count;
        logic [63:0] offset;
        count = (fb_bpp > MAX_BYTES) ? MAX_BYTES : fb_bpp;
        offset = 64'(fb_bpp) * 64'(px.pos_x) + 64'(fb_pitch) * 64'(px.pos_y);
        res.write_valid = fb_enabled && (px.pos_x < fb_limit_x) &&
                          (px.pos_y < fb_limit_y) && (count != 3'd0);
        res.byte_offset = offset[OFFSET_BITS-1:0];
        res.pixel_word  = scale_channel(fb_red_mask, px.rgb_color[23:16]) |
                          scale_channel(fb_green_mask, px.rgb_color[15:8]) |
                          scale_channel(fb_blue_mask, px.rgb_color[7:0]);
        res.byte_count  = count;
        return res;
    endfunction

    // Idle length for either side: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int unsigned r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // One contiguous run of ones at a random place.
    function automatic logic [31:0] run_mask();
        int unsigned w;
        int unsigned sh;
        w  = $urandom_range(1, 32);
        sh = $urandom_range(0, 32 - w);
        return 32'(((64'd1 << w) - 64'd1) << sh);
    endfunction

    // Red, green and blue masks packed as {red, green, blue}.
    function automatic logic [95:0] pick_masks();
        logic [95:0] m;
        case ($urandom_range(0, 7))
            0: m = {32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF};
            1: m = {32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000};
            2: m = {32'h0000_F800, 32'h0000_07E0, 32'h0000_001F};
            3: m = {32'h0000_7C00, 32'h0000_03E0, 32'h0000_001F};
            4: m = {32'h3FF0_0000, 32'h000F_FC00, 32'h0000_03FF};
            5: m = {run_mask(), run_mask(), run_mask()};
            6: m = {32'($urandom()), 32'($urandom()), 32'($urandom())};
            default: m = {32'hFFFF_FFFF, 32'h0000_0000, run_mask()};
        endcase
        return m;
    endfunction

    // Screen limit: sometimes zero or the maximum, usually a modest size.
    function automatic logic [15:0] pick_limit();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 16'h0000;
        end
        if (r == 1) begin
            return 16'hFFFF;
        end
        if (r < 7) begin
            return 16'($urandom_range(1, 2048));
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Coordinate: mostly on screen, sometimes right at the limit or anywhere.
    function automatic logic [15:0] pick_coord(input logic [15:0] limit);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7 && limit != '0) begin
            return 16'($urandom_range(0, limit - 1));
        end
        if (r == 7) begin
            return limit;
        end
        if (r == 8) begin
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
        error_count++;
    endtask

    // One register write; called at a rising edge, returns at the edge of the transfer.
    // cfg_valid is left high so back-to-back writes need no idle between them.
    task automatic write_reg(input cfg_index_e idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_GRAPHICS_ENABLED: fb_enabled    = value[0];
            CFG_BYTES_PER_PIXEL:  fb_bpp        = value[2:0];
            CFG_LINE_PITCH:       fb_pitch      = value[17:0];
            CFG_LIMIT_X:          fb_limit_x    = value[15:0];
            CFG_LIMIT_Y:          fb_limit_y    = value[15:0];
            CFG_RED_MASK:         fb_red_mask   = value;
            CFG_GREEN_MASK:       fb_green_mask = value;
            CFG_BLUE_MASK:        fb_blue_mask  = value;
            default: ;
        endcase
    endtask

    // Writes every register, then releases the configuration channel.
    task automatic apply_settings(input logic enable, input logic [2:0] bpp,
                                  input logic [17:0] pitch, input logic [15:0] lim_x,
                                  input logic [15:0] lim_y, input logic [31:0] red,
                                  input logic [31:0] green, input logic [31:0] blue);
        write_reg(CFG_GRAPHICS_ENABLED, 32'(enable));
        write_reg(CFG_BYTES_PER_PIXEL, 32'(bpp));
        write_reg(CFG_LINE_PITCH, 32'(pitch));
        write_reg(CFG_LIMIT_X, 32'(lim_x));
        write_reg(CFG_LIMIT_Y, 32'(lim_y));
        write_reg(CFG_RED_MASK, red);
        write_reg(CFG_GREEN_MASK, green);
        write_reg(CFG_BLUE_MASK, blue);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [23:0] color, input logic [15:0] x,
                              input logic [15:0] y);
        pixel_in_t px;
        px.rgb_color = color;
        px.pos_x = x;
        px.pos_y = y;
        pixel_pending_q.push_back(px);
        items_sent++;
    endtask

    // Waits until every pixel sent so far has come back, then idles before returning.
    task automatic finish_phase();
        while (results_checked != items_sent) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Driver: offers pending pixels and records the prediction for each transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                pixel_expect_q.push_back(predict_pixel(s_data));
            end
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    s_valid <= 1'b0;
                    tx_gap  <= tx_gap - 1;
                end else if (pixel_pending_q.size() != 0) begin
                    s_data  <= pixel_pending_q.pop_front();
                    s_valid <= 1'b1;
                    tx_gap  <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here once requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= 300;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each result transfer against the oldest prediction.
    always @(posedge aclk) begin
        pixel_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap  <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_expect_q.size() == 0) begin
                    report_mismatch("unexpected transfer", m_data.byte_offset, '0);
                end else begin
                    want = pixel_expect_q.pop_front();
                    if (m_data.write_valid !== want.write_valid) begin
                        report_mismatch("write_valid", m_data.write_valid, want.write_valid);
                    end
                    if (m_data.byte_offset !== want.byte_offset) begin
                        report_mismatch("byte_offset", m_data.byte_offset, want.byte_offset);
                    end
                    if (m_data.pixel_word !== want.pixel_word) begin
                        report_mismatch("pixel_word", m_data.pixel_word, want.pixel_word);
                    end
                    if (m_data.byte_count !== want.byte_count) begin
                        report_mismatch("byte_count", m_data.byte_count, want.byte_count);
                    end
                    results_checked++;
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                m_ready <= 1'b0;
                rx_gap  <= rx_gap - 1;
            end else begin
                m_ready <= 1'b1;
                rx_gap  <= pick_gap();
            end
        end
    end

    // Stimulus: reset, directed corner cases, then randomized phases.
    initial begin
        fb_enabled    = 1'b0;
        fb_bpp        = RESET_BYTES_PER_PIXEL;
        fb_pitch      = '0;
        fb_limit_x    = '0;
        fb_limit_y    = '0;
        fb_red_mask   = '0;
        fb_green_mask = '0;
        fb_blue_mask  = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: graphics off and empty masks, so every write is rejected.
        send_pixel(24'hFFFFFF, 16'd0, 16'd0);
        send_pixel(24'h123456, 16'd100, 16'd200);
        finish_phase();

        // Full-range screen in RGB888 with the largest pitch; both limits are hit.
        apply_settings(1'b1, 3'd4, 18'h3FFFF, 16'hFFFF, 16'hFFFF,
                       32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF);
        send_pixel(24'h000000, 16'd0, 16'd0);
        send_pixel(24'hFFFFFF, 16'hFFFE, 16'hFFFE);
        send_pixel(24'hFF0000, 16'hFFFF, 16'd0);
        send_pixel(24'h00FF00, 16'd0, 16'hFFFF);
        send_pixel(24'h0000FF, 16'd1, 16'd1);
        send_pixel(24'hA5C35A, 16'd640, 16'd480);
        finish_phase();

        // Oversized bytes per pixel with a split red mask, a full green mask and no
        // blue; the corner position makes the offset wrap.
        apply_settings(1'b1, 3'd7, 18'h3FFFF, 16'hFFFF, 16'hFFFF,
                       32'hF00F_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(24'h808080, 16'hFFFE, 16'hFFFE);
        send_pixel(24'h7F0001, 16'd3, 16'd9);
        finish_phase();

        // Zero bytes per pixel rejects everything; single-bit masks at both ends.
        apply_settings(1'b1, 3'd0, 18'd1, 16'd16, 16'd16,
                       32'h8000_0000, 32'h0000_F800, 32'h0000_0001);
        send_pixel(24'hFFFFFF, 16'd1, 16'd1);
        send_pixel(24'h800001, 16'd15, 16'd15);
        finish_phase();

        // Graphics disabled, zero limits and zero pitch.
        apply_settings(1'b0, 3'd5, 18'd0, 16'd0, 16'd0,
                       32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
        send_pixel(24'hFFFFFF, 16'd0, 16'd0);
        send_pixel(24'hFF00FF, 16'hFFFF, 16'hFFFF);
        finish_phase();

        // A typical 16-bit mode around the screen edges.
        apply_settings(1'b1, 3'd2, 18'd1280, 16'd640, 16'd480,
                       32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
        send_pixel(24'hFFFFFF, 16'd639, 16'd479);
        send_pixel(24'hF81F07, 16'd640, 16'd0);
        send_pixel(24'h00FF00, 16'd0, 16'd480);
        send_pixel(24'hFFFFFF, 16'd0, 16'd0);
        finish_phase();

        // Random phases: a new mode per phase; two run without idling, and in the second
        // of them the receiver stalls long enough to back up the input.
        for (int p = 0; p < 10; p++) begin
            logic [95:0] masks;
            logic [2:0]  bpp;
            logic [17:0] pitch;
            logic [23:0] color;
            int unsigned r;
            idle_on = (p != 3 && p != 6);
            masks = pick_masks();
            r = $urandom_range(0, 9);
            bpp = (r < 7) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
            r = $urandom_range(0, 3);
            pitch = (r == 0) ? 18'd0 : (r == 1) ? 18'h3FFFF : 18'($urandom_range(0, 18'h3FFFF));
            apply_settings($urandom_range(0, 7) != 0, bpp, pitch, pick_limit(), pick_limit(),
                           masks[95:64], masks[63:32], masks[31:0]);
            if (p == 6) begin
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
            end
            for (int k = 0; k < 115; k++) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    color = 24'h000000;
                end else if (r == 1) begin
                    color = 24'hFFFFFF;
                end else begin
                    color = 24'($urandom_range(0, 24'hFFFFFF));
                end
                send_pixel(color, pick_coord(fb_limit_x), pick_coord(fb_limit_y));
            end
            finish_phase();
        end

        // Drain: give any stray result time to show up before the verdict.
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
